// ===== sv/lift_can_frame_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// lift can frame decoder assertion macros
// clocked assertion helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef LIFT_CAN_FRAME_DECODER_MACROS_SVH
`define LIFT_CAN_FRAME_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// assertion checked on every rising edge outside reset
`define LCFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lcfd assertion failed");

// assertion checked on every rising edge, reset included
`define LCFD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lcfd assertion failed");

`else

`define LCFD_ASSERT(label, clk, rst_n, prop)
`define LCFD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== sv/lcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcfd_pkg
// types, packet ids, symbol codes and helpers of the lift can frame decoder
// ----------------------------------------------------------------------------
package lcfd_pkg;

    // packet id bases, shifted by the station address
    localparam logic [10:0] ID_P1_BASE  = 11'h506;
    localparam logic [10:0] ID_P2_BASE  = 11'h408;
    localparam logic [10:0] ID_P3_BASE  = 11'h508;
    localparam logic [10:0] ID_P4_BASE  = 11'h50B;
    localparam logic [10:0] ID_P5_BASE  = 11'h606;

    // remote address announce / command pair
    localparam logic [10:0] ID_RA_MASK     = 11'h70F;
    localparam logic [10:0] ID_RA_ANNOUNCE = 11'h401;
    localparam logic [10:0] ID_RA_COMMAND  = 11'h50B;
    localparam logic [3:0]  RA_CMD_WRITE   = 4'd2;
    localparam logic [3:0]  RA_MIN_LEN     = 4'd4;
    localparam logic [4:0]  RA_NONE        = 5'd16;

    localparam logic [3:0]  FRAME_LEN_FULL = 4'd8;

    // symbol codes
    localparam logic [5:0]  SYM_SPACE   = 6'd16;
    localparam logic [5:0]  SYM_BIG_P   = 6'd17;
    localparam logic [5:0]  SYM_SMALL_P = 6'd19;
    localparam logic [5:0]  SYM_HYPHEN  = 6'd22;
    localparam logic [5:0]  SYM_TEN     = 6'd10;
    localparam logic [5:0]  SYM_COUNT   = 6'd38;
    localparam logic [5:0]  SYM_BLANK   = 6'd38;

    // floor numbers
    localparam logic [5:0]  FLOOR_UNKNOWN   = 6'd60;
    localparam logic [6:0]  FLOOR_LIMIT     = 7'd41;
    localparam logic [5:0]  FLOOR_BELOW     = 6'd40;
    localparam logic [5:0]  FLOOR_PARKING   = 6'd50;

    // mode nibble codes of packet one (byte 6 high nibble)
    localparam logic [3:0]  MODE_FIRE       = 4'h7;
    localparam logic [3:0]  MODE_MAINT_A    = 4'h3;
    localparam logic [3:0]  MODE_MAINT_B    = 4'h4;
    localparam logic [3:0]  MODE_MAINT_C    = 4'h5;
    localparam logic [3:0]  MODE_FIREMAN    = 4'hF;
    localparam logic [3:0]  MODE_LADING     = 4'h1;

    // arrow codes
    localparam logic [1:0]  ARROW_NONE = 2'd0;
    localparam logic [1:0]  ARROW_UP   = 2'd1;
    localparam logic [1:0]  ARROW_DOWN = 2'd2;

    typedef enum logic [1:0] {
        ST_DECODED   = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  byte_0;
        logic [7:0]  byte_1;
        logic [7:0]  byte_2;
        logic [7:0]  byte_3;
        logic [7:0]  byte_4;
        logic [7:0]  byte_5;
        logic [7:0]  byte_6;
        logic [7:0]  byte_7;
    } t_item;

    typedef struct packed {
        logic [1:0]  arrow;
        logic        moving;
        logic [5:0]  stop_level;
        logic [3:0]  mode;
        logic [1:0]  overload;
        logic        seismic;
        logic        gong;
        logic [9:0]  lading;
        logic [5:0]  floor_value;
        logic [5:0]  pos_left;
        logic [5:0]  pos_right;
        logic [5:0]  next_left;
        logic [5:0]  next_right;
        logic [4:0]  announced;
    } t_state;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  direction;
        logic [7:0]  flags;
        logic [9:0]  lading_seconds;
        logic [5:0]  floor_number;
        logic [5:0]  position_left;
        logic [5:0]  position_right;
        logic [5:0]  next_left;
        logic [5:0]  next_right;
        logic        address_write_valid;
        logic [3:0]  address_write_value;
    } t_result;

    // left code zero is shown as a space
    function automatic logic [5:0] left_code(input logic [5:0] left);
        return (left == 6'd0) ? SYM_SPACE : left;
    endfunction

    // numeric floor from the two raw position symbols
    function automatic logic [5:0] derive_floor(input logic [5:0] left,
                                                input logic [5:0] right);
        logic [6:0] f;
        logic       r_digit;
        f       = 7'd0;
        r_digit = (right < SYM_TEN);
        if (((left < SYM_TEN) || (left == SYM_SPACE)) && r_digit) begin
            if (left == SYM_SPACE) begin
                f = {1'b0, right};
            end else begin
                f = {left[3:0], 3'b000} + {2'b00, left[3:0], 1'b0} + {1'b0, right};
            end
            return (f < FLOOR_LIMIT) ? f[5:0] : FLOOR_UNKNOWN;
        end
        if ((left == SYM_HYPHEN) && r_digit) begin
            return (right != 6'd0) ? (FLOOR_BELOW + right) : FLOOR_UNKNOWN;
        end
        if (((left == SYM_BIG_P) || (left == SYM_SMALL_P)) && r_digit) begin
            return FLOOR_PARKING + right;
        end
        return FLOOR_UNKNOWN;
    endfunction

endpackage

// ===== sv/lcfd_in_if.sv =====
// ----------------------------------------------------------------------------
// lcfd_in_if
// valid/ready channel carrying one can frame item
// ----------------------------------------------------------------------------
interface lcfd_in_if;
    logic        valid;
    logic        ready;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;

    modport source (
        output valid, frame_id, frame_len,
               byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
        input  ready
    );

    modport sink (
        input  valid, frame_id, frame_len,
               byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
        output ready
    );
endinterface

// ===== sv/lcfd_out_if.sv =====
// ----------------------------------------------------------------------------
// lcfd_out_if
// valid/ready channel carrying one decoded indicator result item
// ----------------------------------------------------------------------------
interface lcfd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] direction;
    logic [7:0] flags;
    logic [9:0] lading_seconds;
    logic [5:0] floor_number;
    logic [5:0] position_left;
    logic [5:0] position_right;
    logic [5:0] next_left;
    logic [5:0] next_right;
    logic       address_write_valid;
    logic [3:0] address_write_value;

    modport source (
        output valid, status, direction, flags, lading_seconds, floor_number,
               position_left, position_right, next_left, next_right,
               address_write_valid, address_write_value,
        input  ready
    );

    modport sink (
        input  valid, status, direction, flags, lading_seconds, floor_number,
               position_left, position_right, next_left, next_right,
               address_write_valid, address_write_value,
        output ready
    );
endinterface

// ===== sv/lift_can_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// lift_can_frame_decoder
// decodes lift indicator can frames into the kept indicator state
// ----------------------------------------------------------------------------
// Accepts one can frame item per clock while the result side is not stalling
// and returns one result item per frame: the frame lands in an input register,
// is decoded against the station address in a single pass of shallow logic
// that also updates the indicator state, and the result waits in an output
// register. The input side keeps accepting while a result waits, as long as
// the input register is free or moving on. The station address register is
// meant to be written only while no item is in flight; the user must keep to
// this, as the block itself does not enforce it.
`include "lift_can_frame_decoder_macros.svh"

module lift_can_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    lcfd_in_if.sink    i_in,
    lcfd_out_if.source o_out
);

    logic                 r_in_valid;
    lcfd_pkg::t_item      r_in;
    logic                 r_out_valid;
    lcfd_pkg::t_result    r_out;
    lcfd_pkg::t_state     r_state;
    logic [3:0]           r_station;

    lcfd_pkg::t_state     n_state;
    lcfd_pkg::t_result    w_res;
    lcfd_pkg::t_status    w_status;
    logic                 w_move;
    logic                 w_in_accept;

    // handshake control
    assign w_move      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_move;
    assign w_in_accept = i_in.valid && i_in.ready;

    // station address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= 4'd0;
        end else if (i_cfg_we) begin
            r_station <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= '{frame_id:  i_in.frame_id,  frame_len: i_in.frame_len,
                      byte_0:    i_in.byte_0,    byte_1:    i_in.byte_1,
                      byte_2:    i_in.byte_2,    byte_3:    i_in.byte_3,
                      byte_4:    i_in.byte_4,    byte_5:    i_in.byte_5,
                      byte_6:    i_in.byte_6,    byte_7:    i_in.byte_7};
        end
    end

    // frame decode and next indicator state
    always_comb begin
        logic [10:0] g4;
        logic [10:0] g6;
        logic [10:0] id_ra;
        logic [3:0]  x;
        logic        hit1;
        logic        hit2;
        logic        hit3;
        logic        hit4;
        logic        hit5;
        logic [5:0]  left;
        logic [5:0]  right;
        logic        wr_valid;
        logic [3:0]  wr_value;

        n_state  = r_state;
        w_status = lcfd_pkg::ST_DECODED;
        wr_valid = 1'b0;
        wr_value = 4'd0;
        x        = r_in.frame_id[7:4];
        id_ra    = r_in.frame_id & lcfd_pkg::ID_RA_MASK;
        g4       = {3'b000, r_station, 4'b0000};
        g6       = {1'b0, r_station, 6'b000000};
        hit1     = (r_in.frame_id == (lcfd_pkg::ID_P1_BASE | g4));
        hit2     = (r_in.frame_id == (lcfd_pkg::ID_P2_BASE | g4));
        hit3     = (r_in.frame_id == (lcfd_pkg::ID_P3_BASE | g4));
        hit4     = (r_in.frame_id == (lcfd_pkg::ID_P4_BASE | g4));
        hit5     = (r_in.frame_id == (lcfd_pkg::ID_P5_BASE | g6));
        left     = 6'd0;
        right    = 6'd0;

        // remote address announce / write command, on every frame
        if (id_ra == lcfd_pkg::ID_RA_ANNOUNCE) begin
            n_state.announced = {1'b0, x};
        end else if ((id_ra == lcfd_pkg::ID_RA_COMMAND) &&
                     (r_in.frame_len >= lcfd_pkg::RA_MIN_LEN)) begin
            if ((r_in.byte_3[7:4] == lcfd_pkg::RA_CMD_WRITE) &&
                ({1'b0, x} == r_state.announced)) begin
                wr_valid = 1'b1;
                wr_value = x;
            end
        end

        // indicator packets
        priority if (!(hit1 || hit2 || hit3 || hit4 || hit5)) begin
            w_status = lcfd_pkg::ST_IGNORED;
        end else if (r_in.frame_len != lcfd_pkg::FRAME_LEN_FULL) begin
            w_status = lcfd_pkg::ST_MALFORMED;
        end else if (hit1) begin
            n_state.arrow      = r_in.byte_6[1:0];
            n_state.moving     = |r_in.byte_6[3:2];
            n_state.stop_level = r_in.byte_3[5:0];
            if (r_in.byte_6[1:0] == lcfd_pkg::ARROW_NONE) begin
                n_state.next_left  = lcfd_pkg::SYM_BLANK;
                n_state.next_right = lcfd_pkg::SYM_BLANK;
            end
            unique case (r_in.byte_6[7:4])
                lcfd_pkg::MODE_FIRE:    n_state.mode = 4'b0001;
                lcfd_pkg::MODE_MAINT_A,
                lcfd_pkg::MODE_MAINT_B,
                lcfd_pkg::MODE_MAINT_C: n_state.mode = 4'b0010;
                lcfd_pkg::MODE_FIREMAN: n_state.mode = 4'b0100;
                lcfd_pkg::MODE_LADING:  n_state.mode = 4'b1000;
                default:                n_state.mode = 4'b0000;
            endcase
        end else if (hit2) begin
            n_state.overload[0] = r_in.byte_7[6];
        end else if (hit3) begin
            left  = r_in.byte_5[5:0];
            right = r_in.byte_6[5:0];
            if ((left >= lcfd_pkg::SYM_COUNT) || (right >= lcfd_pkg::SYM_COUNT)) begin
                w_status = lcfd_pkg::ST_MALFORMED;
            end else begin
                n_state.pos_left    = lcfd_pkg::left_code(left);
                n_state.pos_right   = right;
                n_state.floor_value = lcfd_pkg::derive_floor(left, right);
                n_state.gong        = !r_in.byte_3[6];
                n_state.lading      = ({r_in.byte_3[3:0], 6'b000000}
                                       - {4'b0000, r_in.byte_3[3:0], 2'b00})
                                      + {4'b0000, r_in.byte_2[5:0]};
            end
        end else if (hit4) begin
            n_state.overload[1] = r_in.byte_5[6];
            n_state.seismic     = r_in.byte_0[7];
        end else begin
            // next floor only trusted while moving toward another level
            if (((r_state.arrow == lcfd_pkg::ARROW_UP) ||
                 (r_state.arrow == lcfd_pkg::ARROW_DOWN)) &&
                (r_in.byte_0 != {2'b00, r_state.stop_level})) begin
                left  = r_in.byte_3[5:0];
                right = r_in.byte_4[5:0];
                if ((left >= lcfd_pkg::SYM_COUNT) ||
                    (right >= lcfd_pkg::SYM_COUNT)) begin
                    w_status = lcfd_pkg::ST_MALFORMED;
                end else begin
                    n_state.next_left  = lcfd_pkg::left_code(left);
                    n_state.next_right = right;
                end
            end else begin
                n_state.next_left  = lcfd_pkg::SYM_BLANK;
                n_state.next_right = lcfd_pkg::SYM_BLANK;
            end
        end

        // result item from the updated state
        w_res.status              = w_status;
        w_res.direction           = n_state.arrow;
        w_res.flags               = {n_state.gong, n_state.seismic, |n_state.overload,
                                     n_state.mode[3] || (n_state.lading != 10'd0),
                                     n_state.mode[2], n_state.mode[1], n_state.mode[0],
                                     n_state.moving};
        w_res.lading_seconds      = n_state.lading;
        w_res.floor_number        = n_state.floor_value;
        w_res.position_left       = n_state.pos_left;
        w_res.position_right      = n_state.pos_right;
        w_res.next_left           = n_state.next_left;
        w_res.next_right          = n_state.next_right;
        w_res.address_write_valid = wr_valid;
        w_res.address_write_value = wr_value;
    end

    // indicator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{arrow:       lcfd_pkg::ARROW_NONE,
                         moving:      1'b0,
                         stop_level:  6'd0,
                         mode:        4'd0,
                         overload:    2'd0,
                         seismic:     1'b0,
                         gong:        1'b0,
                         lading:      10'd0,
                         floor_value: lcfd_pkg::FLOOR_UNKNOWN,
                         pos_left:    lcfd_pkg::SYM_BLANK,
                         pos_right:   lcfd_pkg::SYM_BLANK,
                         next_left:   lcfd_pkg::SYM_BLANK,
                         next_right:  lcfd_pkg::SYM_BLANK,
                         announced:   lcfd_pkg::RA_NONE};
        end else if (w_move) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= w_res;
        end
    end

    // output channel
    assign o_out.valid               = r_out_valid;
    assign o_out.status              = r_out.status;
    assign o_out.direction           = r_out.direction;
    assign o_out.flags               = r_out.flags;
    assign o_out.lading_seconds      = r_out.lading_seconds;
    assign o_out.floor_number        = r_out.floor_number;
    assign o_out.position_left       = r_out.position_left;
    assign o_out.position_right      = r_out.position_right;
    assign o_out.next_left           = r_out.next_left;
    assign o_out.next_right          = r_out.next_right;
    assign o_out.address_write_valid = r_out.address_write_valid;
    assign o_out.address_write_value = r_out.address_write_value;

    // an ignored frame other than an address announce leaves the indicator state untouched
    `LCFD_ASSERT(a_ignored_keeps_state, i_clk, i_rst_n, (w_move && (w_status == lcfd_pkg::ST_IGNORED) && (r_in.frame_id & lcfd_pkg::ID_RA_MASK) != lcfd_pkg::ID_RA_ANNOUNCE) |=> (r_state == $past(r_state)))

    // an address write needs a pending announce
    `LCFD_ASSERT(a_write_needs_announce, i_clk, i_rst_n, (w_move && w_res.address_write_valid) |-> !r_state.announced[4])

    // shown floor, left position symbol and right next-floor symbol stay in their tables
    `LCFD_ASSERT(a_codes_in_range, i_clk, i_rst_n, o_out.valid |-> ((o_out.floor_number <= lcfd_pkg::FLOOR_UNKNOWN) && (o_out.position_left <= lcfd_pkg::SYM_BLANK) && (o_out.next_right <= lcfd_pkg::SYM_BLANK)))

    // a held input item is never overwritten
    `LCFD_ASSERT(a_no_overrun, i_clk, i_rst_n, (r_in_valid && !w_move) |-> !i_in.ready)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lift can frame decoder. Directed frames cover
// every packet, each kept mode bit, the symbol rules, the next-floor
// rules and the remote address pair. Random traffic then runs under several
// station addresses. Both channels idle at random. Each accepted frame is
// run through a predictor of the indicator state, and every result item is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    // packet kinds, mapped to ids shifted by the station address
    typedef enum logic [2:0] {
        PK_MOTION     = 3'd0,
        PK_OVERLOAD_A = 3'd1,
        PK_POSITION   = 3'd2,
        PK_OVERLOAD_B = 3'd3,
        PK_NEXT_FLOOR = 3'd4
    } t_packet;

    // kept mode bits
    localparam logic [3:0] MODE_BIT_FIRE    = 4'b0001;
    localparam logic [3:0] MODE_BIT_MAINT   = 4'b0010;
    localparam logic [3:0] MODE_BIT_FIREMAN = 4'b0100;
    localparam logic [3:0] MODE_BIT_LADING  = 4'b1000;

    localparam int PHASE_ITEMS = 275;
    localparam int PHASES      = 6;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [3:0] i_cfg_wdata;

    lcfd_in_if  in_if ();
    lcfd_out_if out_if ();

    lift_can_frame_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // predicted indicator state
    logic [3:0] stn_addr;
    logic [1:0] ind_arrow;
    logic       ind_moving;
    logic [5:0] ind_stop;
    logic [3:0] ind_mode;
    logic [1:0] ind_overload;
    logic       ind_seismic;
    logic       ind_gong;
    logic [9:0] ind_lading;
    logic [5:0] ind_floor;
    logic [5:0] ind_pos_l;
    logic [5:0] ind_pos_r;
    logic [5:0] ind_next_l;
    logic [5:0] ind_next_r;
    logic [4:0] ind_announced;

    lcfd_pkg::t_result expected_results[$];
    int                fault_count;
    logic              steady;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side stalls
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= steady || ($urandom_range(99) >= 8);
        end
    end

    function automatic logic [10:0] packet_id(input t_packet kind);
        case (kind)
            PK_MOTION:     return lcfd_pkg::ID_P1_BASE | {3'b000, stn_addr, 4'b0000};
            PK_OVERLOAD_A: return lcfd_pkg::ID_P2_BASE | {3'b000, stn_addr, 4'b0000};
            PK_POSITION:   return lcfd_pkg::ID_P3_BASE | {3'b000, stn_addr, 4'b0000};
            PK_OVERLOAD_B: return lcfd_pkg::ID_P4_BASE | {3'b000, stn_addr, 4'b0000};
            default:       return lcfd_pkg::ID_P5_BASE | {1'b0, stn_addr, 6'b000000};
        endcase
    endfunction

    function automatic void clear_indicator();
        stn_addr      = 4'd0;
        ind_arrow     = lcfd_pkg::ARROW_NONE;
        ind_moving    = 1'b0;
        ind_stop      = 6'd0;
        ind_mode      = 4'd0;
        ind_overload  = 2'd0;
        ind_seismic   = 1'b0;
        ind_gong      = 1'b0;
        ind_lading    = 10'd0;
        ind_floor     = lcfd_pkg::FLOOR_UNKNOWN;
        ind_pos_l     = lcfd_pkg::SYM_BLANK;
        ind_pos_r     = lcfd_pkg::SYM_BLANK;
        ind_next_l    = lcfd_pkg::SYM_BLANK;
        ind_next_r    = lcfd_pkg::SYM_BLANK;
        ind_announced = lcfd_pkg::RA_NONE;
    endfunction

    // left code zero shows as a space
    function automatic logic [5:0] shown_left(input logic [5:0] code);
        return (code == 6'd0) ? lcfd_pkg::SYM_SPACE : code;
    endfunction

    // floor number from the raw position symbols
    function automatic logic [5:0] floor_of(input logic [5:0] lc, input logic [5:0] rc);
        int n;
        if (rc >= lcfd_pkg::SYM_TEN) return lcfd_pkg::FLOOR_UNKNOWN;
        if (lc == lcfd_pkg::SYM_SPACE || lc < lcfd_pkg::SYM_TEN) begin
            n = (lc == lcfd_pkg::SYM_SPACE) ? int'(rc) : int'(lc) * 10 + int'(rc);
            return (n < int'(lcfd_pkg::FLOOR_LIMIT)) ? 6'(n) : lcfd_pkg::FLOOR_UNKNOWN;
        end
        if (lc == lcfd_pkg::SYM_HYPHEN) begin
            return (rc != 6'd0) ? lcfd_pkg::FLOOR_BELOW + rc : lcfd_pkg::FLOOR_UNKNOWN;
        end
        if (lc == lcfd_pkg::SYM_BIG_P || lc == lcfd_pkg::SYM_SMALL_P) begin
            return lcfd_pkg::FLOOR_PARKING + rc;
        end
        return lcfd_pkg::FLOOR_UNKNOWN;
    endfunction

    // indicator state update of one frame, returns the status
    function automatic lcfd_pkg::t_status apply_frame(input lcfd_pkg::t_item it);
        logic [5:0] lc;
        logic [5:0] rc;
        if (it.frame_id != packet_id(PK_MOTION) && it.frame_id != packet_id(PK_OVERLOAD_A)
                && it.frame_id != packet_id(PK_POSITION)
                && it.frame_id != packet_id(PK_OVERLOAD_B)
                && it.frame_id != packet_id(PK_NEXT_FLOOR)) begin
            return lcfd_pkg::ST_IGNORED;
        end
        if (it.frame_len != lcfd_pkg::FRAME_LEN_FULL) return lcfd_pkg::ST_MALFORMED;

        if (it.frame_id == packet_id(PK_MOTION)) begin
            ind_arrow  = it.byte_6[1:0];
            ind_moving = (it.byte_6[3:2] != 2'b00);
            ind_stop   = it.byte_3[5:0];
            if (ind_arrow == lcfd_pkg::ARROW_NONE) begin
                ind_next_l = lcfd_pkg::SYM_BLANK;
                ind_next_r = lcfd_pkg::SYM_BLANK;
            end
            case (it.byte_6[7:4])
                lcfd_pkg::MODE_FIRE:    ind_mode = MODE_BIT_FIRE;
                lcfd_pkg::MODE_MAINT_A,
                lcfd_pkg::MODE_MAINT_B,
                lcfd_pkg::MODE_MAINT_C: ind_mode = MODE_BIT_MAINT;
                lcfd_pkg::MODE_FIREMAN: ind_mode = MODE_BIT_FIREMAN;
                lcfd_pkg::MODE_LADING:  ind_mode = MODE_BIT_LADING;
                default:                ind_mode = 4'd0;
            endcase
        end else if (it.frame_id == packet_id(PK_OVERLOAD_A)) begin
            ind_overload[0] = it.byte_7[6];
        end else if (it.frame_id == packet_id(PK_POSITION)) begin
            lc = it.byte_5[5:0];
            rc = it.byte_6[5:0];
            if (lc >= lcfd_pkg::SYM_COUNT || rc >= lcfd_pkg::SYM_COUNT) begin
                return lcfd_pkg::ST_MALFORMED;
            end
            ind_pos_l  = shown_left(lc);
            ind_pos_r  = rc;
            ind_floor  = floor_of(lc, rc);
            ind_gong   = ~it.byte_3[6];
            ind_lading = 10'(int'(it.byte_3[3:0]) * 60 + int'(it.byte_2[5:0]));
        end else if (it.frame_id == packet_id(PK_OVERLOAD_B)) begin
            ind_overload[1] = it.byte_5[6];
            ind_seismic     = it.byte_0[7];
        end else begin
            // next floor only trusted while travelling away from the stop level
            if ((ind_arrow == lcfd_pkg::ARROW_UP || ind_arrow == lcfd_pkg::ARROW_DOWN)
                    && it.byte_0 != {2'b00, ind_stop}) begin
                lc = it.byte_3[5:0];
                rc = it.byte_4[5:0];
                if (lc >= lcfd_pkg::SYM_COUNT || rc >= lcfd_pkg::SYM_COUNT) begin
                    return lcfd_pkg::ST_MALFORMED;
                end
                ind_next_l = shown_left(lc);
                ind_next_r = rc;
            end else begin
                ind_next_l = lcfd_pkg::SYM_BLANK;
                ind_next_r = lcfd_pkg::SYM_BLANK;
            end
        end
        return lcfd_pkg::ST_DECODED;
    endfunction

    // expected result item of one accepted frame
    function automatic lcfd_pkg::t_result predict_indicator(input lcfd_pkg::t_item it);
        lcfd_pkg::t_result res;
        logic [3:0]        x;
        res = '0;
        x   = it.frame_id[7:4];

        // remote address announce / command, on every frame
        if ((it.frame_id & lcfd_pkg::ID_RA_MASK) == lcfd_pkg::ID_RA_ANNOUNCE) begin
            ind_announced = {1'b0, x};
        end else if ((it.frame_id & lcfd_pkg::ID_RA_MASK) == lcfd_pkg::ID_RA_COMMAND
                && it.frame_len >= lcfd_pkg::RA_MIN_LEN) begin
            if (it.byte_3[7:4] == lcfd_pkg::RA_CMD_WRITE && {1'b0, x} == ind_announced) begin
                res.address_write_valid = 1'b1;
                res.address_write_value = x;
            end
        end

        res.status         = apply_frame(it);
        res.direction      = ind_arrow;
        res.flags          = {ind_gong, ind_seismic, |ind_overload,
                              ind_mode[3] || (ind_lading != 10'd0),
                              ind_mode[2], ind_mode[1], ind_mode[0], ind_moving};
        res.lading_seconds = ind_lading;
        res.floor_number   = ind_floor;
        res.position_left  = ind_pos_l;
        res.position_right = ind_pos_r;
        res.next_left      = ind_next_l;
        res.next_right     = ind_next_r;
        return res;
    endfunction

    // symbol code biased toward digits and the special symbols
    function automatic logic [5:0] random_symbol();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 6'($urandom_range(9));
        if (r < 50) return lcfd_pkg::SYM_SPACE;
        if (r < 58) return lcfd_pkg::SYM_HYPHEN;
        if (r < 64) return lcfd_pkg::SYM_BIG_P;
        if (r < 70) return lcfd_pkg::SYM_SMALL_P;
        if (r < 93) return 6'($urandom_range(37));
        return 6'($urandom_range(63, 38));
    endfunction

    // mostly well-formed packets, some address pairs, some noise
    function automatic lcfd_pkg::t_item random_frame();
        lcfd_pkg::t_item it;
        logic [95:0]     raw;
        logic [3:0]      x;
        int              pick;
        t_packet         kind;
        raw  = {$urandom, $urandom, $urandom};
        it   = raw[78:0];
        pick = $urandom_range(99);
        if (pick < 10) return it;
        if (pick < 16) begin
            it.frame_id = lcfd_pkg::ID_RA_ANNOUNCE | {3'b000, it.frame_id[7:4], 4'b0000};
            return it;
        end
        if (pick < 24) begin
            x = ($urandom_range(1) == 0 && !ind_announced[4]) ? ind_announced[3:0]
                                                              : it.frame_id[7:4];
            it.frame_id  = lcfd_pkg::ID_RA_COMMAND | {3'b000, x, 4'b0000};
            it.frame_len = 4'($urandom_range(8, 3));
            if ($urandom_range(3) != 0) it.byte_3[7:4] = lcfd_pkg::RA_CMD_WRITE;
            return it;
        end

        if ($urandom_range(19) != 0) it.frame_len = lcfd_pkg::FRAME_LEN_FULL;
        kind        = t_packet'(3'($urandom_range(4)));
        it.frame_id = packet_id(kind);
        case (kind)
            PK_POSITION: begin
                it.byte_5[5:0] = random_symbol();
                it.byte_6[5:0] = random_symbol();
                if ($urandom_range(4) == 0) begin
                    it.byte_3[3:0] = 4'd0;
                    it.byte_2[5:0] = 6'd0;
                end
            end
            PK_NEXT_FLOOR: begin
                it.byte_3[5:0] = random_symbol();
                it.byte_4[5:0] = random_symbol();
                if ($urandom_range(3) == 0) it.byte_0 = {2'b00, ind_stop};
            end
            default: begin
            end
        endcase
        return it;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) note_fault($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // check every result item against the oldest prediction
    always @(posedge i_clk) begin : result_check
        lcfd_pkg::t_result got;
        lcfd_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.status, out_if.direction, out_if.flags, out_if.lading_seconds,
                   out_if.floor_number, out_if.position_left, out_if.position_right,
                   out_if.next_left, out_if.next_right, out_if.address_write_valid,
                   out_if.address_write_value};
            if (expected_results.size() == 0) begin
                note_fault("result item with no frame waiting");
            end else begin
                want = expected_results.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("direction", want.direction, got.direction);
                compare_field("flags", want.flags, got.flags);
                compare_field("lading_seconds", want.lading_seconds, got.lading_seconds);
                compare_field("floor_number", want.floor_number, got.floor_number);
                compare_field("position_left", want.position_left, got.position_left);
                compare_field("position_right", want.position_right, got.position_right);
                compare_field("next_left", want.next_left, got.next_left);
                compare_field("next_right", want.next_right, got.next_right);
                compare_field("address_write_valid", want.address_write_valid,
                              got.address_write_valid);
                compare_field("address_write_value", want.address_write_value,
                              got.address_write_value);
            end
        end
    end

    // drive one frame item, with random idle cycles ahead of it
    task automatic send_frame(input lcfd_pkg::t_item it);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 8) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        {in_if.frame_id, in_if.frame_len, in_if.byte_0, in_if.byte_1, in_if.byte_2,
         in_if.byte_3, in_if.byte_4, in_if.byte_5, in_if.byte_6, in_if.byte_7} <= it;
        do @(posedge i_clk); while (!in_if.ready);
        expected_results.push_back(predict_indicator(it));
    endtask

    // hold the input until every result item is back
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_station(input logic [3:0] addr);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= addr;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        stn_addr = addr;
    endtask

    // data bytes are written byte_0 first
    task automatic test_motion_and_mode();
        send_frame({11'h000, lcfd_pkg::FRAME_LEN_FULL, 64'h0});
        send_frame({packet_id(PK_MOTION), 4'd7, 64'h00_00_00_05_00_00_75_00});
        send_frame({packet_id(PK_MOTION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_05_00_00_75_00});
        send_frame({packet_id(PK_MOTION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_3F_00_00_F2_00});
        send_frame({packet_id(PK_MOTION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_C0_00_00_4F_00});
        send_frame({packet_id(PK_MOTION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_00_00_00_10_00});
    endtask

    task automatic test_overload_seismic();
        send_frame({packet_id(PK_OVERLOAD_A), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_00_00_00_00_40});
        send_frame({packet_id(PK_OVERLOAD_B), lcfd_pkg::FRAME_LEN_FULL,
                    64'h80_00_00_00_00_40_00_00});
        send_frame({packet_id(PK_OVERLOAD_A), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_00_00_00_00_BF});
    endtask

    task automatic test_position_symbols();
        // left zero as space, gong, lading time
        send_frame({packet_id(PK_POSITION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_3B_03_00_00_05_00});
        send_frame({packet_id(PK_POSITION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_C0_40_00_02_03_00});
        // two digits past the top floor
        send_frame({packet_id(PK_POSITION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_00_00_04_05_00});
        // below ground with the longest lading time
        send_frame({packet_id(PK_POSITION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_3F_0F_00_16_03_00});
        send_frame({packet_id(PK_POSITION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_00_00_D1_09_00});
        // symbols out of the table
        send_frame({packet_id(PK_POSITION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_00_00_26_01_00});
        send_frame({packet_id(PK_POSITION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_00_00_01_3F_00});
    endtask

    task automatic test_next_floor();
        send_frame({packet_id(PK_MOTION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_07_00_00_01_00});
        send_frame({packet_id(PK_NEXT_FLOOR), lcfd_pkg::FRAME_LEN_FULL,
                    64'h03_00_00_00_09_00_00_00});
        send_frame({packet_id(PK_NEXT_FLOOR), lcfd_pkg::FRAME_LEN_FULL,
                    64'h03_00_00_02_26_00_00_00});
        // destination equal to the stop level blanks the next floor
        send_frame({packet_id(PK_NEXT_FLOOR), lcfd_pkg::FRAME_LEN_FULL,
                    64'h07_00_00_00_00_00_00_00});
    endtask

    task automatic test_remote_address();
        send_frame({lcfd_pkg::ID_RA_ANNOUNCE | {3'b000, 4'd9, 4'b0000}, 4'd0, 64'h0});
        send_frame({lcfd_pkg::ID_RA_COMMAND | {3'b000, 4'd9, 4'b0000}, lcfd_pkg::RA_MIN_LEN,
                    64'h00_00_00_20_00_00_00_00});
        send_frame({lcfd_pkg::ID_RA_COMMAND | {3'b000, 4'd9, 4'b0000}, 4'd3,
                    64'h00_00_00_20_00_00_00_00});
    endtask

    task automatic test_station_extremes();
        set_station(4'd15);
        send_frame({packet_id(PK_MOTION), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_01_00_00_02_00});
        send_frame({lcfd_pkg::ID_P1_BASE, lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_01_00_00_00_00});
        send_frame({packet_id(PK_NEXT_FLOOR), lcfd_pkg::FRAME_LEN_FULL,
                    64'h00_00_00_11_02_00_00_00});
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) set_station(4'd0);
            else if (p == 1) set_station(4'd15);
            else set_station(4'($urandom_range(15)));
            // one phase without random idle cycles on either side, apart from the wait_idle drains
            steady = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(59) == 0) wait_idle();
                send_frame(random_frame());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 4'd0;
        steady      = 1'b0;
        fault_count = 0;
        in_if.valid = 1'b0;
        {in_if.frame_id, in_if.frame_len, in_if.byte_0, in_if.byte_1, in_if.byte_2,
         in_if.byte_3, in_if.byte_4, in_if.byte_5, in_if.byte_6, in_if.byte_7} = '0;
        clear_indicator();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_motion_and_mode();
        test_overload_seismic();
        test_position_symbols();
        test_next_floor();
        test_remote_address();
        test_station_extremes();
        test_random_traffic();

        wait_idle();
        repeat (4) @(negedge i_clk);
        if (expected_results.size() != 0) note_fault("result items missing at end");
        if (fault_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
